>>> hw/rtl/fw2d_pkg.sv
`timescale 1ns / 1ps
package fw2d_pkg;
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;
  localparam int SZW = 9;
  localparam int SZ_W = 13;
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CORNER, ST_ROWSTEP, ST_READ, ST_WAIT, ST_WRITE,
    ST_MUL1, ST_MUL2, ST_MUL3, ST_OUT
  } fw_state_t;

  // low set bit of a value
  function automatic logic [SZ_W-1:0] low_bit(input logic [SZ_W-1:0] v);
    return v & (~v + SZ_W'(1));
  endfunction
endpackage

>>> hw/rtl/fenwick_2d_range_add_range_sum.sv
`timescale 1ns / 1ps
// two-dimensional range-add / range-sum grid of 64-bit wrapping cells.
// in_ channel: one beat per command; tuser carries cmd (0 add, 1 query).
// in_tdata from the lowest bit: row_lo[8:0], col_lo, row_hi, col_hi, delta[31:0],
// zero padded to 72 bits.
// out_ channel: one beat per query, tdata = rect_sum[63:0]; adds give no beat.
// cfg_: write rows_in_use (index 0) or cols_in_use (index 1) while idle.
// one item at a time: each of four corners walks its fenwick row path, and per
// row its column path, one tree cell at a time (read, wait, write or
// accumulate states) in one shared memory holding all four trees.
// a corner walks the rows on its path, and per row the columns on its path
// (at most log2(size)+1 each); a query adds the MUL1, MUL2 and MUL3 combine
// states per corner, and each item returns to the idle state before the next.
// after reset a clearing pass writes zero to all 2**(rw+cw) entries (65536 at
// 256x256), with in_tready low. a result waits in the output register while
// the receiver stalls; the next command is accepted meanwhile, and a following
// query holds in its last state until the register frees.
module fenwick_2d_range_add_range_sum import fw2d_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // row_lo, col_lo, row_hi, col_hi, delta
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // rect_sum
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;

  logic [SZW-1:0] rows_r, cols_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SZW'(256);
      cols_r <= SZW'(256);
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS) rows_r <= cfg_wdata;
      else cols_r <= cfg_wdata;
    end
  end
  logic [SZ_W-1:0] nr, nc;
  assign nr = ({4'd0, rows_r} > SZ_W'(MAX_ROWS)) ? SZ_W'(MAX_ROWS) : {4'd0, rows_r};
  assign nc = ({4'd0, cols_r} > SZ_W'(MAX_COLS)) ? SZ_W'(MAX_COLS) : {4'd0, cols_r};

  fw_state_t st_r, st_nxt;
  logic [AW:0] clr_r;
  logic cmd_r;
  logic [SZ_W-1:0] rl_r, cl_r, rh_r, ch_r;
  logic [63:0] d_r;
  logic [1:0] k_r;
  logic [SZ_W-1:0] x_r, y_r, i_r, j_r;
  logic [63:0] v_r, wr_r, wc_r, wb_r;
  logic [63:0] s1_r, s2_r, s3_r, s4_r, m1_r, m2_r, m3_r, acc_r;
  logic ov_r;
  logic [63:0] od_r;

  logic mwe;
  logic [AW-1:0] maddr_w, maddr_r;
  logic [255:0] wdat, rdat;
  fw2d_mem #(.AW(AW)) u_mem (.clk, .we(mwe), .waddr(maddr_w), .wdata(wdat),
                            .raddr(maddr_r), .rdata(rdat));

  // corner selection: 0 (lo,lo) 1 (lo,hi) 2 (hi,lo) 3 (hi,hi); queries swap lo/hi
  logic [SZ_W-1:0] cx, cy;
  logic csign, cskip;
  always_comb begin
    if (cmd_r == CMD_ADD) begin
      cx = k_r[1] ? rh_r + SZ_W'(1) : rl_r;
      cy = k_r[0] ? ch_r + SZ_W'(1) : cl_r;
      cskip = (cx > nr) || (cy > nc);
    end else begin
      cx = k_r[1] ? rl_r - SZ_W'(1) : rh_r;
      cy = k_r[0] ? cl_r - SZ_W'(1) : ch_r;
      if (cx > nr) cx = nr;
      if (cy > nc) cy = nc;
      cskip = 1'b0;
    end
    csign = k_r[1] ^ k_r[0];
  end

  logic is_add;
  assign is_add = (cmd_r == CMD_ADD);
  logic [SZ_W-1:0] jn, in_;
  assign jn = is_add ? j_r + low_bit(j_r) : j_r - low_bit(j_r);
  assign in_ = is_add ? i_r + low_bit(i_r) : i_r - low_bit(i_r);
  logic jdone, idone;
  assign jdone = is_add ? (jn > nc) : (jn == '0);
  assign idone = is_add ? (in_ > nr) : (in_ == '0);
  logic rowok;
  assign rowok = is_add ? (i_r <= nr) && (y_r <= nc) && (y_r != '0)
                        : (i_r != '0) && (y_r != '0);
  logic corner_end;
  assign corner_end = !rowok || (jdone && idone);

  logic [AW-1:0] cell_addr;
  assign cell_addr = {RW'(i_r - SZ_W'(1)), CW'(j_r - SZ_W'(1))};
  assign maddr_r = cell_addr;
  assign maddr_w = (st_r == ST_CLEAR) ? clr_r[AW-1:0] : cell_addr;
  // only a live add cell is written back
  assign mwe = (st_r == ST_CLEAR) || (st_r == ST_WRITE && is_add && rowok);
  assign wdat = (st_r == ST_CLEAR) ? '0 :
                {rdat[255:192] + wb_r, rdat[191:128] + wc_r,
                 rdat[127:64] + wr_r, rdat[63:0] + v_r};

  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_r == (AW+1)'(2**AW - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (in_tvalid && in_tready) st_nxt = ST_CORNER;
      ST_CORNER: st_nxt = ST_ROWSTEP;
      ST_ROWSTEP: st_nxt = rowok ? ST_READ : ST_WRITE;
      ST_READ: st_nxt = ST_WAIT;
      ST_WAIT: st_nxt = ST_WRITE;
      ST_WRITE: begin
        if (corner_end) begin
          if (!is_add) st_nxt = ST_MUL1;
          else if (k_r == 2'd3) st_nxt = ST_IDLE;
          else st_nxt = ST_CORNER;
        end else if (jdone) st_nxt = ST_ROWSTEP;
        else st_nxt = ST_READ;
      end
      ST_MUL1: st_nxt = ST_MUL2;
      ST_MUL2: st_nxt = ST_MUL3;
      ST_MUL3: st_nxt = (k_r == 2'd3) ? ST_OUT : ST_CORNER;
      ST_OUT: if (!ov_r || out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic [63:0] vv;
  assign vv = csign ? (~d_r + 64'd1) : d_r;
  logic [SZ_W-1:0] xm1, ym1;
  assign xm1 = cx - SZ_W'(1);
  assign ym1 = cy - SZ_W'(1);
  logic [63:0] pfx;
  assign pfx = m1_r + m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + (AW+1)'(1);
      if (out_tready) ov_r <= 1'b0;
      if (st_r == ST_OUT && (!ov_r || out_tready)) ov_r <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        cmd_r <= in_tuser;
        rl_r <= (in_tdata[8:0] == '0) ? SZ_W'(1) : SZ_W'(in_tdata[8:0]);
        cl_r <= (in_tdata[17:9] == '0) ? SZ_W'(1) : SZ_W'(in_tdata[17:9]);
        rh_r <= SZ_W'(in_tdata[26:18]);
        ch_r <= SZ_W'(in_tdata[35:27]);
        d_r <= {{32{in_tdata[67]}}, in_tdata[67:36]};
        k_r <= 2'd0;
        acc_r <= '0;
      end
      ST_CORNER: begin
        x_r <= cx; y_r <= cy; i_r <= cskip ? SZ_W'(MAX_ROWS + 1) : cx;
        v_r <= vv; wr_r <= vv * 64'(xm1); wc_r <= vv * 64'(ym1);
        s1_r <= '0; s2_r <= '0; s3_r <= '0; s4_r <= '0;
      end
      ST_ROWSTEP: begin
        j_r <= y_r;
        if (is_add) wb_r <= wr_r * 64'(y_r - SZ_W'(1));
      end
      ST_WRITE: begin
        if (!is_add && rowok) begin
          s1_r <= s1_r + rdat[63:0]; s2_r <= s2_r + rdat[127:64];
          s3_r <= s3_r + rdat[191:128]; s4_r <= s4_r + rdat[255:192];
        end
        if (rowok && jdone) i_r <= in_;
        else j_r <= jn;
        if (is_add && corner_end) k_r <= k_r + 2'd1;
      end
      // prefix combine: s1*x*y - y*s2 - x*s3 + s4 in states MUL1, MUL2 and MUL3
      ST_MUL1: begin
        m1_r <= s1_r * 64'(x_r);
        m2_r <= s2_r * 64'(y_r);
        m3_r <= s3_r * 64'(x_r);
      end
      ST_MUL2: begin
        m1_r <= m1_r * 64'(y_r);
        m2_r <= s4_r - m2_r - m3_r;
      end
      ST_MUL3: begin
        acc_r <= csign ? acc_r - pfx : acc_r + pfx;
        k_r <= k_r + 2'd1;
      end
      default: ;
    endcase
    if (st_r == ST_OUT && (!ov_r || out_tready)) od_r <= acc_r;
  end

  // assertions
`ifndef SYNTHESIS
  a_noin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLEAR |-> !in_tready) else $error("accept during clear");
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mwe |-> (st_r == ST_CLEAR || st_r == ST_WRITE)) else $error("stray write");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result lost");
`endif
endmodule

>>> hw/rtl/fw2d_mem.sv
`timescale 1ns / 1ps
module fw2d_mem import fw2d_pkg::*; #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [255:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [255:0]  rdata
);
  // four trees side by side in one wide word
  logic [255:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import fw2d_pkg::*;

  localparam int GRID_DIM = 256;
  localparam int SETTLE_CYCLES = 500;
  localparam longint CYCLE_LIMIT = 10000000;
  localparam int HOLD_CYCLES = 3000;

  // grid model: four weighted 2-d fenwick trees and the pending query sums
  class grid_scoreboard;
    bit [63:0] plain_t [GRID_DIM*GRID_DIM];
    bit [63:0] row_t [GRID_DIM*GRID_DIM];
    bit [63:0] col_t [GRID_DIM*GRID_DIM];
    bit [63:0] both_t [GRID_DIM*GRID_DIM];
    int unsigned rows_used = 256;
    int unsigned cols_used = 256;
    bit [63:0] sum_queue [$];
    int errors = 0;

    function void set_size(logic idx, logic [8:0] val);
      if (idx == CFG_ROWS) rows_used = val;
      else cols_used = val;
    endfunction

    function int unsigned eff_rows();
      return (rows_used > GRID_DIM) ? GRID_DIM : rows_used;
    endfunction

    function int unsigned eff_cols();
      return (cols_used > GRID_DIM) ? GRID_DIM : cols_used;
    endfunction

    function void corner_add(int x, int y, bit [63:0] v);
      int nr, nc, at;
      bit [63:0] wr, wc, wb;
      nr = eff_rows();
      nc = eff_cols();
      if (x == 0 || y == 0 || x > nr || y > nc) return;
      wr = v * 64'(x - 1);
      wc = v * 64'(y - 1);
      wb = wr * 64'(y - 1);
      for (int i = x; i <= nr; i += i & -i) begin
        for (int j = y; j <= nc; j += j & -j) begin
          at = (i - 1) * GRID_DIM + (j - 1);
          plain_t[at] += v;
          row_t[at] += wr;
          col_t[at] += wc;
          both_t[at] += wb;
        end
      end
    endfunction

    function bit [63:0] prefix_sum(int x, int y);
      bit [63:0] s1, s2, s3, s4;
      int at;
      s1 = 0; s2 = 0; s3 = 0; s4 = 0;
      if (x > eff_rows()) x = eff_rows();
      if (y > eff_cols()) y = eff_cols();
      for (int i = x; i != 0; i -= i & -i) begin
        for (int j = y; j != 0; j -= j & -j) begin
          at = (i - 1) * GRID_DIM + (j - 1);
          s1 += plain_t[at];
          s2 += row_t[at];
          s3 += col_t[at];
          s4 += both_t[at];
        end
      end
      return s1 * 64'(x) * 64'(y) - 64'(y) * s2 - 64'(x) * s3 + s4;
    endfunction

    // accepted command: update the trees or queue the expected sum
    function void note_item(logic cmd, int rl, int cl, int rh, int ch, logic [31:0] delta);
      bit [63:0] d;
      d = {{32{delta[31]}}, delta};
      if (rl == 0) rl = 1;
      if (cl == 0) cl = 1;
      if (cmd == CMD_ADD) begin
        corner_add(rl, cl, d);
        corner_add(rl, ch + 1, -d);
        corner_add(rh + 1, cl, -d);
        corner_add(rh + 1, ch + 1, d);
      end else begin
        sum_queue.push_back(prefix_sum(rh, ch) - prefix_sum(rh, cl - 1)
                            - prefix_sum(rl - 1, ch) + prefix_sum(rl - 1, cl - 1));
      end
    endfunction

    function void check_sum(logic [63:0] actual);
      bit [63:0] want;
      if (sum_queue.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, actual);
        errors++;
        return;
      end
      want = sum_queue.pop_front();
      if (want !== actual) begin
        $display("%0t: rect_sum mismatch, expected %h actual %h", $time, want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return sum_queue.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;  // row_lo, col_lo, row_hi, col_hi, delta
  logic        in_tuser = 0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;      // rect_sum
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [8:0]  cfg_wdata = '0;

  grid_scoreboard sb = new();
  bit     sender_idles = 1;
  bit     hold_req = 0;
  longint cycles = 0;

  fenwick_2d_range_add_range_sum dut (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sum(out_tdata);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else if (sender_idles && $urandom_range(0, 9) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_tready <= 1;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // one command beat, held until accepted
  task automatic send_item(logic cmd, int rl, int cl, int rh, int ch, logic [31:0] delta);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {4'b0, delta, 9'(ch), 9'(rh), 9'(cl), 9'(rl)};
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, rl & 9'h1FF, cl & 9'h1FF, rh & 9'h1FF, ch & 9'h1FF, delta);
    @(negedge clk);
  endtask

  // wait for all results and for the last command to finish
  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    while (!in_tready) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_size(logic idx, logic [8:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_size(idx, val);
  endtask

  // mostly valid rectangles inside the grid, some arbitrary bounds
  task automatic random_item(int nr, int nc);
    int rl, rh, cl, ch;
    logic [31:0] d;
    if ($urandom_range(0, 4) != 0 && nr > 0 && nc > 0) begin
      rl = $urandom_range(1, nr); rh = $urandom_range(rl, nr);
      cl = $urandom_range(1, nc); ch = $urandom_range(cl, nc);
    end else begin
      rl = $urandom_range(0, 511); rh = $urandom_range(0, 511);
      cl = $urandom_range(0, 511); ch = $urandom_range(0, 511);
    end
    case ($urandom_range(0, 7))
      0: d = 32'h7FFF_FFFF;
      1: d = 32'h8000_0000;
      2: d = $urandom_range(0, 20) - 10;
      default: d = $urandom;
    endcase
    send_item($urandom_range(0, 1) ? CMD_QUERY : CMD_ADD, rl, cl, rh, ch, d);
  endtask

  initial begin
    int rows_list [8] = '{16, 1, 511, 0, 7, 256, 300, 12};
    int cols_list [8] = '{16, 1, 300, 5, 256, 3, 511, 9};
    int count_list [8] = '{500, 100, 40, 50, 150, 150, 40, 700};
    int nr, nc;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: reset size, extremes and odd bounds
    send_item(CMD_QUERY, 1, 1, 256, 256, 0);
    send_item(CMD_ADD, 1, 1, 256, 256, 32'h7FFF_FFFF);
    send_item(CMD_QUERY, 1, 1, 256, 256, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 1, 1, 1, 1, 32'h8000_0000);
    send_item(CMD_ADD, 256, 256, 256, 256, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 1, 1, 1, 1, 0);
    send_item(CMD_QUERY, 256, 256, 256, 256, 0);
    send_item(CMD_QUERY, 0, 0, 2, 2, 0);                  // low bound of zero
    send_item(CMD_ADD, 0, 0, 3, 3, 5);
    send_item(CMD_ADD, 10, 20, 5, 8, 7);                  // inverted rectangle
    send_item(CMD_QUERY, 10, 20, 5, 8, 0);
    send_item(CMD_ADD, 200, 200, 511, 511, 32'h1234_5678); // past the grid
    send_item(CMD_QUERY, 100, 100, 511, 511, 0);
    send_item(CMD_QUERY, 511, 511, 511, 511, 0);
    send_item(CMD_ADD, 129, 3, 255, 254, 32'h5555_AAAA);
    send_item(CMD_QUERY, 1, 1, 256, 256, 0);
    send_item(CMD_QUERY, 128, 2, 200, 255, 0);

    for (int p = 0; p < 8; p++) begin
      write_size(CFG_ROWS, 9'(rows_list[p]));
      write_size(CFG_COLS, 9'(cols_list[p]));
      nr = rows_list[p] > 256 ? 256 : rows_list[p];
      nc = cols_list[p] > 256 ? 256 : cols_list[p];
      if (p == 7) sender_idles = 0;
      for (int k = 0; k < count_list[p]; k++) begin
        if (p == 0 && k == 100) hold_req = 1;
        if (p == 0 && k == 300) drain();
        random_item(nr, nc);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/fw2d_pkg.sv
hw/rtl/fw2d_mem.sv
hw/rtl/fenwick_2d_range_add_range_sum.sv
test/testbench.sv
